// ----- src/aabb_frustum_cull_assert.svh -----
// assertion macros used by the checker
`ifndef AABB_FRUSTUM_CULL_ASSERT_SVH
`define AABB_FRUSTUM_CULL_ASSERT_SVH

// implication checked on every rising clock edge outside reset
`define AFC_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("aabb_frustum_cull assertion failed");

// condition that must never be seen outside reset
`define AFC_ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("aabb_frustum_cull assertion failed");

`endif

// ----- src/afc_pkg.sv -----
`default_nettype none

package afc_pkg;

	localparam int NUM_PLANES    = 6;
	localparam int COORD_BITS    = 20;
	localparam int REG_COUNT     = 6;
	localparam int N_BITS        = 14;
	localparam int D_BITS        = 22;
	localparam int D_SHIFT       = 12;
	localparam int NX_LSB        = 0;
	localparam int NY_LSB        = 14;
	localparam int NZ_LSB        = 28;
	localparam int D_LSB         = 42;
	localparam int CFG_DATA_BITS = 64;
	localparam int CFG_IDX_BITS  = 3;
	localparam int PROD_BITS     = N_BITS + COORD_BITS;
	localparam int DTERM_BITS    = D_BITS + D_SHIFT;
	localparam int DIST_BITS     = ((PROD_BITS > DTERM_BITS) ? PROD_BITS : DTERM_BITS) + 2;

	typedef logic signed [COORD_BITS-1:0] coord_t;
	typedef logic signed [N_BITS-1:0]     norm_t;
	typedef logic signed [D_BITS-1:0]     offs_t;
	typedef logic signed [PROD_BITS-1:0]  prod_t;
	typedef logic signed [DIST_BITS-1:0]  dist_t;
	typedef logic [CFG_DATA_BITS-1:0]     plane_t;

	typedef struct packed {
		logic                     en;
		logic [CFG_IDX_BITS-1:0]  index;
		logic [CFG_DATA_BITS-1:0] data;
	} cfg_wr_t;

endpackage

`default_nettype wire

// ----- src/afc_plane_regs.sv -----
`default_nettype none

module afc_plane_regs (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire afc_pkg::cfg_wr_t cfg,
	output afc_pkg::plane_t       planes [afc_pkg::NUM_PLANES]
);

	afc_pkg::plane_t regs_q [afc_pkg::REG_COUNT];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < afc_pkg::REG_COUNT; i++) begin
				regs_q[i] <= '0;
			end
		end else begin
			for (int i = 0; i < afc_pkg::REG_COUNT; i++) begin
				if (cfg.en && cfg.index == afc_pkg::CFG_IDX_BITS'(i)) begin
					regs_q[i] <= cfg.data;
				end
			end
		end
	end

	// planes without a register read as zero and never cull
	for (genvar p = 0; p < afc_pkg::NUM_PLANES; p++) begin : g_plane
		if (p < afc_pkg::REG_COUNT) begin : g_reg
			assign planes[p] = regs_q[p];
		end else begin : g_zero
			assign planes[p] = '0;
		end
	end

endmodule

`default_nettype wire

// ----- src/afc_plane_eval.sv -----
`default_nettype none

module afc_plane_eval (
	input  wire logic            clk,
	input  wire afc_pkg::plane_t plane,
	input  wire afc_pkg::coord_t lo [3],
	input  wire afc_pkg::coord_t hi [3],
	output logic                 neg_s3
);

	afc_pkg::norm_t n [3];
	afc_pkg::offs_t d;
	afc_pkg::coord_t sel [3];
	afc_pkg::prod_t prod_s2 [3];
	afc_pkg::dist_t dterm_s2;
	afc_pkg::dist_t dist_sum;

	assign n[0] = afc_pkg::norm_t'(plane[afc_pkg::NX_LSB +: afc_pkg::N_BITS]);
	assign n[1] = afc_pkg::norm_t'(plane[afc_pkg::NY_LSB +: afc_pkg::N_BITS]);
	assign n[2] = afc_pkg::norm_t'(plane[afc_pkg::NZ_LSB +: afc_pkg::N_BITS]);
	assign d    = afc_pkg::offs_t'(plane[afc_pkg::D_LSB +: afc_pkg::D_BITS]);

	// positive vertex: max corner where the normal component is not negative
	always_comb begin
		for (int a = 0; a < 3; a++) begin
			sel[a] = n[a][afc_pkg::N_BITS-1] ? lo[a] : hi[a];
		end
	end

	always_ff @(posedge clk) begin
		for (int a = 0; a < 3; a++) begin
			prod_s2[a] <= afc_pkg::prod_t'(n[a]) * afc_pkg::prod_t'(sel[a]);
		end
		dterm_s2 <= afc_pkg::dist_t'(d) <<< afc_pkg::D_SHIFT;
	end

	assign dist_sum = afc_pkg::dist_t'(prod_s2[0]) + afc_pkg::dist_t'(prod_s2[1])
		+ afc_pkg::dist_t'(prod_s2[2]) + dterm_s2;

	always_ff @(posedge clk) begin
		neg_s3 <= dist_sum[afc_pkg::DIST_BITS-1];
	end

endmodule

`default_nettype wire

// ----- src/aabb_frustum_cull.sv -----
// channel   | handshake                | payload
// ----------+--------------------------+--------------------------------------
// box in    | start, busy              | box_min_x/y/z, box_max_x/y/z
// result    | done (strobe)            | visible
// config    | cfg_wr_en                | cfg_index, cfg_data
//
// one box per cycle, busy stays low; four pipeline registers (input, products,
// plane sums, result) carry each box, and done is carried beside them through
// valid_s1, valid_s2, valid_s3 and done_q, so it rises with the result.
// the plane multipliers set the stage depth. reset clears the valid bits, the
// result strobe and the plane registers. the result cannot be held off, and no
// transaction is dropped or repeated.

`default_nettype none

module aabb_frustum_cull (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                start,
	output logic                                     busy,
	input  wire afc_pkg::coord_t                     box_min_x,
	input  wire afc_pkg::coord_t                     box_min_y,
	input  wire afc_pkg::coord_t                     box_min_z,
	input  wire afc_pkg::coord_t                     box_max_x,
	input  wire afc_pkg::coord_t                     box_max_y,
	input  wire afc_pkg::coord_t                     box_max_z,
	output logic                                     done,
	output logic                                     visible,
	input  wire logic                                cfg_wr_en,
	input  wire logic [afc_pkg::CFG_IDX_BITS-1:0]    cfg_index,
	input  wire logic [afc_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

	afc_pkg::cfg_wr_t cfg;
	afc_pkg::plane_t  planes [afc_pkg::NUM_PLANES];
	afc_pkg::coord_t  lo_s1 [3];
	afc_pkg::coord_t  hi_s1 [3];
	logic             valid_s1;
	logic             valid_s2;
	logic             valid_s3;
	logic [afc_pkg::NUM_PLANES-1:0] neg_s3;
	logic             accept;
	logic             done_q;
	logic             visible_q;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	assign cfg.en    = cfg_wr_en;
	assign cfg.index = cfg_index;
	assign cfg.data  = cfg_data;

	afc_plane_regs u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.planes (planes)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			lo_s1[0] <= box_min_x;
			lo_s1[1] <= box_min_y;
			lo_s1[2] <= box_min_z;
			hi_s1[0] <= box_max_x;
			hi_s1[1] <= box_max_y;
			hi_s1[2] <= box_max_z;
		end
	end

	for (genvar p = 0; p < afc_pkg::NUM_PLANES; p++) begin : g_eval
		afc_plane_eval u_eval (
			.clk    (clk),
			.plane  (planes[p]),
			.lo     (lo_s1),
			.hi     (hi_s1),
			.neg_s3 (neg_s3[p])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= accept;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
			done_q   <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		visible_q <= ~|neg_s3;
	end

	assign done    = done_q;
	assign visible = visible_q;

endmodule

`default_nettype wire

// ----- src/afc_checker.sv -----
`default_nettype none

`include "aabb_frustum_cull_assert.svh"

module afc_checker (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire logic busy,
	input wire logic done
);

	`AFC_ASSERT_NEVER(a_never_busy, clk, arst_n, busy)
	`AFC_ASSERT_IMPLY(a_result_follows, clk, arst_n, start && !busy, ##4 done)
	`AFC_ASSERT_IMPLY(a_no_extra_result, clk, arst_n, !(start && !busy), ##4 !done)

endmodule

bind aabb_frustum_cull afc_checker u_afc_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);

`default_nettype wire
